FILE: design/assert_macros.svh
// assertion macros used by the top level of the highpass fir
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/fhp_pkg.sv
// constants, coefficient table and coefficient rescaling for the highpass fir
// no dependencies
package fhp_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int OUT_W         = 27;
  localparam int TAP_COUNT     = 21;
  localparam int HALF_TAPS     = 11;
  localparam int Q30_FRAC      = 30;
  localparam int COEF_FRAC_DEF = 30;
  localparam int OUT_FRAC_BITS = 16;

  localparam longint OUT_MAX = 64'sd67108863;
  localparam longint OUT_MIN = -64'sd67108864;

  // taps 0..10 in q2.30, tap k mirrors tap 20-k
  localparam longint TAP_Q30 [HALF_TAPS] = '{
    -64'sd6, -64'sd185, -64'sd1133, -64'sd4042, -64'sd10625, -64'sd22431,
    -64'sd39803, -64'sd60958, -64'sd81880, -64'sd97401, 64'sd1073638685
  };

  // coefficient of tap k with frac fraction bits, rounded half up
  function automatic longint fhp_coef(input int k, input int frac);
    int     idx;
    int     s;
    longint v;
    idx = (k < HALF_TAPS) ? k : (TAP_COUNT - 1 - k);
    if (idx >= HALF_TAPS || idx < 0) begin
      idx = HALF_TAPS - 1;
    end
    v = TAP_Q30[idx];
    s = Q30_FRAC - frac;
    if (s > 0) begin
      v = (v + (64'sd1 <<< (s - 1))) >>> s;
    end
    return v;
  endfunction

endpackage

FILE: design/fhp_tap_cell.sv
// one cell of the transposed tap chain: constant product plus neighbor sum
// depends on fhp_pkg
module fhp_tap_cell #(
  parameter int     COEF_W = fhp_pkg::COEF_FRAC_DEF + 2,
  parameter int     ACC_W  = fhp_pkg::COEF_FRAC_DEF + 12,
  parameter longint COEF   = 64'sd0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [fhp_pkg::SAMPLE_W-1:0]      sample,
  input  logic signed [ACC_W-1:0]           partial_in,
  output logic signed [ACC_W-1:0]           partial_out
);
  import fhp_pkg::*;

  localparam logic signed [COEF_W-1:0] CoefVal = COEF_W'(COEF);

  logic signed [SAMPLE_W+COEF_W:0] product;
  logic signed [ACC_W-1:0]         partial_next;

  // sample times this cell's coefficient, added to the upstream partial sum
  assign product      = $signed({1'b0, sample}) * CoefVal;
  assign partial_next = ACC_W'(product) + partial_in;

  // partial sum register, cleared so the history starts at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_out <= '0;
    end else if (en) begin
      partial_out <= partial_next;
    end
  end

endmodule

FILE: design/fhp_out_stage.sv
// output register: rounds the accumulator to q11.16 and saturates
// depends on fhp_pkg
module fhp_out_stage #(
  parameter int COEF_FRAC_BITS = fhp_pkg::COEF_FRAC_DEF,
  parameter int ACC_W          = fhp_pkg::COEF_FRAC_DEF + 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               acc_valid,
  input  logic signed [ACC_W-1:0]            acc,
  input  logic                               out_ready,
  output logic                               take,
  output logic                               out_valid,
  output logic signed [fhp_pkg::OUT_W-1:0]   filtered
);
  import fhp_pkg::*;

  localparam int SHIFT = COEF_FRAC_BITS - OUT_FRAC_BITS;
  localparam int Y_W   = ACC_W + 1 - SHIFT;
  localparam logic signed [ACC_W:0] Half = (ACC_W + 1)'(64'sd1 <<< (SHIFT - 1));
  localparam logic signed [Y_W-1:0] YMax = Y_W'(OUT_MAX);
  localparam logic signed [Y_W-1:0] YMin = Y_W'(OUT_MIN);

  logic signed [ACC_W:0]     rnd;
  logic signed [Y_W-1:0]     y;
  logic signed [OUT_W-1:0]   filtered_next;

  // round half up, then clamp to the output range
  assign rnd = $signed({acc[ACC_W-1], acc}) + Half;
  assign y   = Y_W'(rnd >>> SHIFT);

  always_comb begin
    if (y > YMax) begin
      filtered_next = OUT_W'(YMax);
    end else if (y < YMin) begin
      filtered_next = OUT_W'(YMin);
    end else begin
      filtered_next = OUT_W'(y);
    end
  end

  // output register frees up when empty or when the transfer completes
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && acc_valid) begin
      filtered <= filtered_next;
    end
  end

endmodule

FILE: design/fir_highpass_21tap_top.sv
// top level of the 21-tap highpass fir for a 10-bit ecg sample stream
// depends on fhp_pkg, fhp_tap_cell, fhp_out_stage, assert_macros.svh
//
// usage:
//   input channel: sample (unsigned 10 bits) with in_valid / in_ready.
//   output channel: filtered (signed 27 bits, q11.16, saturating) with
//   out_valid / out_ready. every input transfer gives exactly one output.
//   flow: a sample taken goes into the sum register in cell 0, then into the
//   output register, from which its output transfer completes.
//   throughput: one sample per cycle while out_ready is high, set by the
//   transposed tap chain, where each of the 21 cells adds its constant
//   product to its neighbor's partial sum; rounding and clamping sit in
//   the output register. cell 0 holds the full sum, the first pipeline register.
//   stall: while out_ready is low a result holds in the output register and
//   one more sample can still be taken into the sum register; after that
//   in_ready drops until the output transfer completes.
//   reset: rst (synchronous, active high) clears all partial sums, which is
//   a delay line of zero samples, and empties both pipeline registers.
`include "assert_macros.svh"

module fir_highpass_21tap_top #(
  parameter int COEF_FRAC_BITS = fhp_pkg::COEF_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fhp_pkg::SAMPLE_W-1:0]       sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fhp_pkg::OUT_W-1:0]   filtered
);
  import fhp_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int ACC_W  = COEF_FRAC_BITS + 12;

  logic                    accept;
  logic                    acc_valid;
  logic                    take;
  logic signed [ACC_W-1:0] part [TAP_COUNT+1];

  // sum register can load when empty or when its item moves on
  assign in_ready = !acc_valid || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (in_ready) begin
      acc_valid <= in_valid;
    end
  end

  // transposed chain: cell k takes the partial sum of cell k+1
  assign part[TAP_COUNT] = '0;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    fhp_tap_cell #(
      .COEF_W (COEF_W),
      .ACC_W  (ACC_W),
      .COEF   (fhp_coef(k, COEF_FRAC_BITS))
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (accept),
      .sample      (sample),
      .partial_in  (part[k+1]),
      .partial_out (part[k])
    );
  end

  // round, clamp and hold the result for the receiver
  fhp_out_stage #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (ACC_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .acc_valid (acc_valid),
    .acc       (part[0]),
    .out_ready (out_ready),
    .take      (take),
    .out_valid (out_valid),
    .filtered  (filtered)
  );

  // a held sum is never overwritten by a new sample
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst, !(acc_valid && !take) || !in_ready)
  // a transfer in always fills the sum register
  `ASSERT_NEXT(a_accept_fills, clk, rst, accept, acc_valid)
  // a sum moving on always lands in the output register
  `ASSERT_NEXT(a_sum_moves_out, clk, rst, acc_valid && take, out_valid)

endmodule
